@@ rtl/bftm_pkg.sv @@
// Shared constants, codes and item types for the tape-machine stepper.
package bftm_pkg;

  localparam int PROG_DEPTH = 4096;
  localparam int TAPE_DEPTH = 32768;

  localparam int PROG_AW = $clog2(PROG_DEPTH);
  localparam int TAPE_AW = $clog2(TAPE_DEPTH);
  localparam int PC_W    = $clog2(PROG_DEPTH + 1);

  localparam int KIND_W = 2;
  localparam int ADDR_W = 13;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 3;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STEP  = 2'd2;

  localparam logic [STAT_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [STAT_W-1:0] ST_RUN   = 3'd1;
  localparam logic [STAT_W-1:0] ST_HALT  = 3'd2;
  localparam logic [STAT_W-1:0] ST_OPEN  = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLOSE = 3'd4;

  localparam logic [BYTE_W-1:0] CMD_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] CMD_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] CMD_INC   = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_DEC   = 8'h2D;
  localparam logic [BYTE_W-1:0] CMD_OUT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CMD_IN    = 8'h2C;
  localparam logic [BYTE_W-1:0] CMD_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CMD_CLOSE = 8'h5D;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] value;
  } bftm_item_t;

  typedef struct packed {
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              took_input;
    logic [STAT_W-1:0] status;
  } bftm_res_t;

endpackage

@@ rtl/bftm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module bftm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bftm_exec.sv @@
// Instruction sequencer: program and tape memories, bracket scans, tape clear sweep.
module bftm_exec (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bftm_pkg::bftm_item_t in_item,
  output logic                res_valid,
  input  logic                res_ready,
  output bftm_pkg::bftm_res_t  res
);
  import bftm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FWD   = 3'd2;
  localparam logic [2:0] S_BWD   = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]         state, state_next;
  logic [PC_W-1:0]    pc, pc_next, prog_len, prog_len_next;
  logic [TAPE_AW-1:0] cp, cp_next, clr_addr, clr_addr_next;
  logic [PC_W-1:0]    nest, nest_next, nest_adj;
  logic [STAT_W-1:0]  run_status, status_next;
  logic               clr_reply, clr_reply_next;
  bftm_res_t          res_q, res_next;
  logic [BYTE_W-1:0]  item_value;

  logic               prog_we, tape_we;
  logic [BYTE_W-1:0]  prog_rdata, tape_rdata, tape_wdata;
  logic [TAPE_AW-1:0] tape_waddr;
  logic [PC_W-1:0]    pc_inc, pc_dec, start_len;
  logic               step_fin;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = res_q;
  assign pc_inc    = pc + 1'b1;
  assign pc_dec    = pc - 1'b1;
  assign start_len = (32'(in_item.address) > PROG_DEPTH) ? PC_W'(PROG_DEPTH)
                                                         : PC_W'(in_item.address);

  always_comb begin
    state_next     = state;
    pc_next        = pc;
    cp_next        = cp;
    nest_next      = nest;
    nest_adj       = nest;
    prog_len_next  = prog_len;
    status_next    = run_status;
    clr_addr_next  = clr_addr;
    clr_reply_next = clr_reply;
    res_next       = res_q;
    prog_we        = 1'b0;
    tape_we        = 1'b0;
    tape_waddr     = cp;
    tape_wdata     = tape_rdata;
    step_fin       = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_next   = '0;
          state_next = S_DONE;
          case (in_item.kind)
            KIND_LOAD: begin
              prog_we = (32'(in_item.address) < PROG_DEPTH);
            end
            KIND_START: begin
              prog_len_next  = start_len;
              pc_next        = '0;
              cp_next        = '0;
              nest_next      = '0;
              status_next    = (start_len == '0) ? ST_HALT : ST_RUN;
              clr_addr_next  = '0;
              clr_reply_next = 1'b1;
              state_next     = S_CLEAR;
            end
            KIND_STEP: begin
              if (run_status == ST_RUN) begin
                state_next = S_EXEC;
              end
            end
            default: ;
          endcase
        end
      end

      S_EXEC: begin
        step_fin = 1'b1;
        case (prog_rdata)
          CMD_RIGHT: cp_next = (cp == TAPE_AW'(TAPE_DEPTH - 1)) ? '0 : cp + 1'b1;
          CMD_LEFT:  cp_next = (cp == '0) ? TAPE_AW'(TAPE_DEPTH - 1) : cp - 1'b1;
          CMD_INC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata + 1'b1;
          end
          CMD_DEC: begin
            tape_we    = 1'b1;
            tape_wdata = tape_rdata - 1'b1;
          end
          CMD_OUT: begin
            res_next.out_valid = 1'b1;
            res_next.out_byte  = tape_rdata;
          end
          CMD_IN: begin
            tape_we             = 1'b1;
            tape_wdata          = item_value;
            res_next.took_input = 1'b1;
          end
          CMD_OPEN: begin
            if (tape_rdata == '0) begin
              step_fin  = 1'b0;
              nest_next = PC_W'(1);
              pc_next   = pc_inc;
              if (pc_inc >= prog_len) begin
                status_next = ST_OPEN;
                state_next  = S_DONE;
              end else begin
                state_next = S_FWD;
              end
            end
          end
          CMD_CLOSE: begin
            if (tape_rdata != '0) begin
              step_fin  = 1'b0;
              nest_next = PC_W'(1);
              if (pc == '0) begin
                status_next = ST_CLOSE;
                state_next  = S_DONE;
              end else begin
                pc_next    = pc_dec;
                state_next = S_BWD;
              end
            end
          end
          default: ;
        endcase
      end

      // Forward scan: prog_rdata holds the byte at pc.
      S_FWD: begin
        if (prog_rdata == CMD_OPEN) begin
          nest_adj = nest + 1'b1;
        end else if (prog_rdata == CMD_CLOSE) begin
          nest_adj = nest - 1'b1;
        end
        nest_next = nest_adj;
        if (nest_adj == '0) begin
          step_fin = 1'b1;
        end else begin
          pc_next = pc_inc;
          if (pc_inc >= prog_len) begin
            status_next = ST_OPEN;
            state_next  = S_DONE;
          end
        end
      end

      S_BWD: begin
        if (prog_rdata == CMD_OPEN) begin
          nest_adj = nest - 1'b1;
        end else if (prog_rdata == CMD_CLOSE) begin
          nest_adj = nest + 1'b1;
        end
        nest_next = nest_adj;
        if (nest_adj == '0) begin
          step_fin = 1'b1;
        end else if (pc == '0) begin
          status_next = ST_CLOSE;
          state_next  = S_DONE;
        end else begin
          pc_next = pc_dec;
        end
      end

      S_CLEAR: begin
        tape_we       = 1'b1;
        tape_waddr    = clr_addr;
        tape_wdata    = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == TAPE_AW'(TAPE_DEPTH - 1)) begin
          state_next = clr_reply ? S_DONE : S_IDLE;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Normal end of an instruction: advance past it, halt at the end.
    if (step_fin) begin
      pc_next    = pc_inc;
      state_next = S_DONE;
      if (pc_inc >= prog_len) begin
        status_next = ST_HALT;
      end
    end

    if (state != S_DONE) begin
      res_next.status = status_next;
    end
  end

  // Program read follows pc_next so that the byte at pc is ready each cycle.
  bftm_ram #(.WIDTH(BYTE_W), .DEPTH(PROG_DEPTH)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (in_item.address[PROG_AW-1:0]),
    .wdata (in_item.value),
    .raddr (pc_next[PROG_AW-1:0]),
    .rdata (prog_rdata)
  );

  bftm_ram #(.WIDTH(BYTE_W), .DEPTH(TAPE_DEPTH)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (cp),
    .rdata (tape_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      pc         <= '0;
      cp         <= '0;
      nest       <= '0;
      prog_len   <= '0;
      run_status <= ST_IDLE;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
    end else begin
      state      <= state_next;
      pc         <= pc_next;
      cp         <= cp_next;
      nest       <= nest_next;
      prog_len   <= prog_len_next;
      run_status <= status_next;
      clr_addr   <= clr_addr_next;
      clr_reply  <= clr_reply_next;
    end
  end

  always_ff @(posedge clk) begin
    res_q <= res_next;
    if (in_valid && in_ready) begin
      item_value <= in_item.value;
    end
  end

`ifndef SYNTHESIS
  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    (run_status == ST_RUN) |-> (pc < prog_len))
    else $error("running with pc at or past program length");

  a_scan_nest: assert property (@(posedge clk) disable iff (rst)
    (state == S_FWD || state == S_BWD) |-> (nest != '0))
    else $error("bracket scan with zero nesting count");

  a_tape_write_src: assert property (@(posedge clk) disable iff (rst)
    tape_we |-> (state == S_EXEC || state == S_CLEAR))
    else $error("tape written outside execute or clear");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("pending result changed before it was taken");
`endif

endmodule

@@ rtl/bf_tape_machine_step.sv @@
// Top level of the tape-machine stepper: stream ports and output register.
//
// Usage: one input transaction per item on s_axis_*. s_axis_tuser carries the
// kind (load program byte, start, step); s_axis_tdata carries address and value.
// Every accepted item yields exactly one result transaction on m_axis_*:
// output flag, output byte, input-taken flag and the run status.
//
// Result path:
//  - load, step while not running, unused kind: result register in the sequencer,
//    then output register.
//  - step: program/tape memory read, execute with tape write-back, output
//    register; a taken bracket adds a scan that reads one program byte per cycle.
//  - start: the tape memory is cleared one entry per cycle, then the result
//    passes to the output register.
// Reset: synchronous, active high. After reset the tape clear sweep runs over
// all TAPE_DEPTH (32768) entries with s_axis_tready low; no result is produced.
// Items are taken one at a time: s_axis_tready is high only while the
// sequencer is idle. A finished result sits in the output register while the
// next item is accepted; if the receiver stalls, the next result waits in the
// sequencer and input is held off until the output register drains.
module bf_tape_machine_step (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [12:0] address, [20:13] value, [23:21] zero
  input  logic [bftm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] kind
  input  logic [bftm_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] out_valid, [8:1] out_byte, [9] took_input, [12:10] status, [15:13] zero
  output logic [bftm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import bftm_pkg::*;

  bftm_item_t item;
  bftm_res_t  res;
  logic       res_valid, res_ready;

  // Unpack the input transaction into item fields.
  assign item.kind    = s_axis_tuser;
  assign item.address = s_axis_tdata[ADDR_W-1:0];
  assign item.value   = s_axis_tdata[ADDR_W+BYTE_W-1:ADDR_W];

  bftm_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or draining this cycle.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {(OUT_TDATA_W - STAT_W - BYTE_W - 2)'(0), res.status,
                       res.took_input, res.out_byte, res.out_valid};
    end
  end

endmodule
